>>> sv/irp_pkg.sv
// Shared types, constants and the digit table for the integer radix printer.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package irp_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned BcdDigits    = 10;
  localparam int unsigned MaxChars     = 11;
  localparam int unsigned BitsPerStage = 8;
  localparam int unsigned DabbleStages = DataWidth / BitsPerStage;
  localparam int unsigned OctDigits    = (DataWidth + 2) / 3;
  localparam int unsigned HexDigits    = DataWidth / 4;
  localparam int unsigned CountWidth   = 4;

  typedef enum logic [1:0] {
    KindUdec = 2'd0,
    KindSdec = 2'd1,
    KindOct  = 2'd2,
    KindHex  = 2'd3
  } kind_e;

  typedef logic [3:0]            nibble_t;
  typedef logic [7:0]            char_t;
  typedef logic [CountWidth-1:0] count_t;

  localparam char_t CharMinus = 8'h2D;
  localparam char_t CharX     = 8'h78;
  localparam char_t CharSpace = 8'h20;
  localparam char_t CharZero  = 8'h30;

  localparam char_t DigitTable [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // Word moving through the binary-to-BCD stages
  typedef struct packed {
    kind_e                  kind;
    logic                   neg;
    logic [DataWidth-1:0]   mag;
    logic [DataWidth-1:0]   sh;
    logic [4*BcdDigits-1:0] bcd;
  } conv_t;

  function automatic char_t digit_char(nibble_t d);
    return DigitTable[d];
  endfunction

endpackage

`default_nettype wire

>>> sv/integer_to_ascii_radix_printer.sv
// Top level of the integer radix printer: input register, BCD stages,
// digit formatting and the character serializer. Uses irp_pkg, irp_dabble_stage.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one word: kind_i selects
//   unsigned decimal, signed decimal, octal or hexadecimal, value_i the value.
//   Output channel (out_valid_o / out_ready_i) gives each word as ASCII
//   characters, most significant first, with last_o high on the final character.
// Path: an accepted word passes the input register, four BCD stages, the digit
//   scan and the character build before its first character is shown.
// Throughput: while out_ready_i is high the serializer sends one character per
//   cycle; a word has 1 to 11 characters, and the next word's characters follow
//   the previous last character with no gap when that word is already waiting.
//   The pipeline ahead of the serializer holds up to seven further words.
// Reset: rst_ni clears all valid bits and the serializer; nothing is shown
//   until a new word arrives.
// Stall: while out_ready_i is low the current character holds, the pipeline
//   fills behind it, and in_ready_o drops once every stage is occupied.
module integer_to_ascii_radix_printer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       char_code_o,
  output logic             last_o
);

  localparam int unsigned NumStg = irp_pkg::DabbleStages;

  // ---------------------------------------------------------------- input stage
  logic           s0_valid_q;
  irp_pkg::conv_t s0_data_d;
  irp_pkg::conv_t s0_data_q;

  irp_pkg::conv_t    stg_data  [NumStg+1];
  logic [NumStg:0]   stg_valid;
  logic [NumStg:0]   stg_ready;

  // Take the magnitude of negative signed values
  always_comb begin
    s0_data_d.kind = irp_pkg::kind_e'(kind_i);
    s0_data_d.neg  = (s0_data_d.kind == irp_pkg::KindSdec) && value_i[irp_pkg::DataWidth-1];
    s0_data_d.mag  = s0_data_d.neg ?
                     ((~value_i) + {{(irp_pkg::DataWidth-1){1'b0}}, 1'b1}) : value_i;
    s0_data_d.sh   = s0_data_d.mag;
    s0_data_d.bcd  = '0;
  end

  assign in_ready_o = !s0_valid_q || stg_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s0_valid_q <= 1'b1;
    end else if (stg_ready[0]) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s0_data_q <= s0_data_d;
    end
  end

  assign stg_valid[0] = s0_valid_q;
  assign stg_data[0]  = s0_data_q;

  // ---------------------------------------------------------------- BCD stages
  for (genvar g = 0; g < NumStg; g++) begin : g_dabble
    irp_dabble_stage u_dabble (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (stg_valid[g]),
      .in_ready_o (stg_ready[g]),
      .in_data_i  (stg_data[g]),
      .out_valid_o(stg_valid[g+1]),
      .out_ready_i(stg_ready[g+1]),
      .out_data_o (stg_data[g+1])
    );
  end

  // ---------------------------------------------------------------- digit scan
  logic              s5_valid_q;
  logic              s5_ready;
  irp_pkg::kind_e    s5_kind_q;
  logic              s5_neg_q;
  logic              s5_nonzero_q;
  irp_pkg::nibble_t  s5_dig_d [irp_pkg::MaxChars];
  irp_pkg::nibble_t  s5_dig_q [irp_pkg::MaxChars];
  irp_pkg::count_t   s5_ndig_d;
  irp_pkg::count_t   s5_ndig_q;
  irp_pkg::conv_t    s5_in;

  logic              s6_ready;

  assign s5_in = stg_data[NumStg];

  // Lay out the digits least significant first and find the top nonzero one
  always_comb begin
    for (int i = 0; i < irp_pkg::MaxChars; i++) begin
      s5_dig_d[i] = '0;
    end
    case (s5_in.kind)
      irp_pkg::KindOct: begin
        for (int i = 0; i < irp_pkg::OctDigits - 1; i++) begin
          s5_dig_d[i] = {1'b0, s5_in.mag[3*i +: 3]};
        end
        s5_dig_d[irp_pkg::OctDigits-1] = {2'b00, s5_in.mag[irp_pkg::DataWidth-1 -: 2]};
      end
      irp_pkg::KindHex: begin
        for (int i = 0; i < irp_pkg::HexDigits; i++) begin
          s5_dig_d[i] = s5_in.mag[4*i +: 4];
        end
      end
      default: begin
        for (int i = 0; i < irp_pkg::BcdDigits; i++) begin
          s5_dig_d[i] = s5_in.bcd[4*i +: 4];
        end
      end
    endcase
    s5_ndig_d = irp_pkg::count_t'(1);
    for (int i = 0; i < irp_pkg::MaxChars; i++) begin
      if (s5_dig_d[i] != 4'd0) begin
        s5_ndig_d = irp_pkg::count_t'(i + 1);
      end
    end
  end

  assign s5_ready              = !s5_valid_q || s6_ready;
  assign stg_ready[NumStg]     = s5_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (stg_valid[NumStg] && s5_ready) begin
      s5_valid_q <= 1'b1;
    end else if (s6_ready) begin
      s5_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_valid[NumStg] && s5_ready) begin
      s5_kind_q    <= s5_in.kind;
      s5_neg_q     <= s5_in.neg;
      s5_nonzero_q <= |s5_in.mag;
      s5_dig_q     <= s5_dig_d;
      s5_ndig_q    <= s5_ndig_d;
    end
  end

  // ---------------------------------------------------------------- character build
  logic              s6_valid_q;
  irp_pkg::char_t    s6_chars_d [irp_pkg::MaxChars];
  irp_pkg::char_t    s6_chars_q [irp_pkg::MaxChars];
  irp_pkg::count_t   s6_lastpos_d;
  irp_pkg::count_t   s6_lastpos_q;
  logic [1:0]        s6_plen;
  logic              s6_slen;
  logic [4:0]        s6_first;
  logic [4:0]        s6_end;
  logic [4:0]        s6_idx;

  logic              ser_ready;

  // Place prefix, digits most significant first, then the trailing space
  always_comb begin
    s6_plen = 2'd0;
    if (s5_kind_q == irp_pkg::KindHex) begin
      s6_plen = 2'd2;
    end else if (s5_kind_q == irp_pkg::KindSdec && s5_neg_q) begin
      s6_plen = 2'd1;
    end
    s6_slen      = (s5_kind_q == irp_pkg::KindUdec) && s5_nonzero_q;
    s6_first     = {3'b000, s6_plen};
    s6_end       = s6_first + {1'b0, s5_ndig_q};
    s6_lastpos_d = irp_pkg::count_t'(s6_end + {4'b0000, s6_slen} - 5'd1);
    s6_idx       = '0;
    for (int i = 0; i < irp_pkg::MaxChars; i++) begin
      if (5'(i) < s6_first) begin
        if (s5_kind_q == irp_pkg::KindHex) begin
          s6_chars_d[i] = (i == 0) ? irp_pkg::CharZero : irp_pkg::CharX;
        end else begin
          s6_chars_d[i] = irp_pkg::CharMinus;
        end
      end else if (5'(i) < s6_end) begin
        s6_idx        = s6_end - 5'd1 - 5'(i);
        s6_chars_d[i] = irp_pkg::digit_char(s5_dig_q[s6_idx[3:0]]);
      end else begin
        s6_chars_d[i] = irp_pkg::CharSpace;
      end
    end
  end

  assign s6_ready = !s6_valid_q || ser_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (s5_valid_q && s6_ready) begin
      s6_valid_q <= 1'b1;
    end else if (ser_ready) begin
      s6_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_valid_q && s6_ready) begin
      s6_chars_q   <= s6_chars_d;
      s6_lastpos_q <= s6_lastpos_d;
    end
  end

  // ---------------------------------------------------------------- serializer
  logic              busy_q;
  irp_pkg::count_t   pos_q;
  irp_pkg::count_t   lastpos_q;
  irp_pkg::char_t    buf_q [irp_pkg::MaxChars];
  logic              ser_last;

  assign ser_last  = (pos_q == lastpos_q);
  assign ser_ready = !busy_q || (out_ready_i && ser_last);

  // Load a new word when idle or on the last character's handoff, else step through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pos_q     <= '0;
      lastpos_q <= '0;
    end else if (s6_valid_q && ser_ready) begin
      busy_q    <= 1'b1;
      pos_q     <= '0;
      lastpos_q <= s6_lastpos_q;
    end else if (busy_q && out_ready_i) begin
      if (ser_last) begin
        busy_q <= 1'b0;
      end else begin
        pos_q <= pos_q + irp_pkg::count_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s6_valid_q && ser_ready) begin
      buf_q <= s6_chars_q;
    end
  end

  assign out_valid_o = busy_q;
  assign char_code_o = buf_q[pos_q];
  assign last_o      = ser_last;

endmodule

`default_nettype wire

>>> sv/irp_dabble_stage.sv
// One registered slice of the shift-and-add-3 binary-to-BCD converter.
// Handles BitsPerStage magnitude bits per word; uses irp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irp_dabble_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire irp_pkg::conv_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output irp_pkg::conv_t     out_data_o
);

  logic           valid_q;
  irp_pkg::conv_t data_d;
  irp_pkg::conv_t data_q;

  // Shift the next magnitude bits into the BCD digits, adjusting first
  always_comb begin
    data_d = in_data_i;
    for (int s = 0; s < irp_pkg::BitsPerStage; s++) begin
      for (int d = 0; d < irp_pkg::BcdDigits; d++) begin
        if (data_d.bcd[4*d +: 4] >= 4'd5) begin
          data_d.bcd[4*d +: 4] = data_d.bcd[4*d +: 4] + 4'd3;
        end
      end
      {data_d.bcd, data_d.sh} = {data_d.bcd[4*irp_pkg::BcdDigits-2:0], data_d.sh, 1'b0};
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the word
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

>>> sv/irp_checker.sv
// Port-level checks for the integer radix printer, bound to the top level.
// Sees only the top-level ports; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module irp_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [7:0]  char_code_i,
  input wire logic        last_i
);

  // Hold a stalled character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(char_code_i) && $stable(last_i))
    else $error("stalled output word changed");

  // Drop output valid out of reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

  // Emit only digits, prefix characters or the trailing space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (char_code_i >= 8'h30 && char_code_i <= 8'h39) ||
                    (char_code_i >= 8'h41 && char_code_i <= 8'h46) ||
                    char_code_i == 8'h2D || char_code_i == 8'h78 || char_code_i == 8'h20)
    else $error("unexpected character code");

  // A space ends a word; a sign or an x never does
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (char_code_i != 8'h20 || last_i) &&
                    ((char_code_i != 8'h2D && char_code_i != 8'h78) || !last_i))
    else $error("last flag misplaced");

endmodule

bind integer_to_ascii_radix_printer irp_port_checker u_irp_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .char_code_i (char_code_o),
  .last_i      (last_o)
);

`default_nettype wire

>>> verif/irp_checker.sv
// Scoreboard for the integer radix printer: predicts the ASCII characters of
// each accepted word and compares them with the output channel. Uses irp_pkg.
`timescale 1ns / 1ps

module irp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  char_code_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam irp_pkg::char_t CharUpperA = 8'h41;

  typedef struct packed {
    irp_pkg::char_t code;
    logic           last;
  } char_exp_t;

  char_exp_t expected_chars [$];

  // Append the characters one word prints, most significant first
  function automatic void queue_expected_chars(irp_pkg::kind_e fmt, logic [31:0] word);
    irp_pkg::char_t text [$];
    irp_pkg::char_t digits [$];
    logic [31:0]    mag;
    int unsigned    radix;
    int unsigned    d;
    char_exp_t      ch;
    mag = word;
    case (fmt)
      irp_pkg::KindOct: radix = 8;
      irp_pkg::KindHex: radix = 16;
      default: radix = 10;
    endcase
    // sign and prefix come ahead of the digits
    if (fmt == irp_pkg::KindSdec && word[31]) begin
      text.push_back(irp_pkg::CharMinus);
      mag = -word;
    end
    if (fmt == irp_pkg::KindHex) begin
      text.push_back(irp_pkg::CharZero);
      text.push_back(irp_pkg::CharX);
    end
    // peel digits off the low end, so each goes to the front
    if (mag == 0) digits.push_front(irp_pkg::CharZero);
    while (mag != 0) begin
      d = mag % radix;
      digits.push_front((d < 10) ? irp_pkg::char_t'(irp_pkg::CharZero + d) :
                                   irp_pkg::char_t'(CharUpperA + d - 10));
      mag = mag / radix;
    end
    foreach (digits[i]) text.push_back(digits[i]);
    // unsigned decimal trails a space unless the word is zero
    if (fmt == irp_pkg::KindUdec && word != 0) text.push_back(irp_pkg::CharSpace);
    foreach (text[i]) begin
      ch.code = text[i];
      ch.last = (i == text.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  // Predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin : watch
    char_exp_t head;
    int        errs;
    if (!rst_ni) begin
      expected_chars.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      errs = 0;
      if (in_valid_i && in_ready_i) begin
        queue_expected_chars(irp_pkg::kind_e'(kind_i), value_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $error("char_code: no character expected, got %h", char_code_i);
          errs++;
        end else begin
          head = expected_chars.pop_front();
          if (char_code_i !== head.code) begin
            $error("char_code: expected %h, got %h", head.code, char_code_i);
            errs++;
          end
          if (last_i !== head.last) begin
            $error("last: expected %b, got %b", head.last, last_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= expected_chars.size();
    end
  end

endmodule

>>> verif/tb_top.sv
// Top of the integer radix printer testbench: clock, reset, word stimulus
// and output backpressure. Uses irp_pkg, irp_checker and the printer itself.
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit  = 500000;
  localparam int RandomWords = 352;
  localparam int PhaseWords  = 44;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  kind      = '0;
  logic [31:0] value     = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  char_code;
  logic        last_char;

  int fail_count;
  int pending;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int cycle_count = 0;

  integer_to_ascii_radix_printer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .char_code_o (char_code),
    .last_o      (last_char)
  );

  irp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .kind_i       (kind),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .char_code_i  (char_code),
    .last_i       (last_char),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Randomly stall the output channel
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one word and hold it until accepted; valid stays high afterwards
  task automatic send_word(irp_pkg::kind_e fmt, logic [31:0] word);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= fmt;
    value    <= word;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Drop valid and hold off until every predicted character has come out
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [31:0] word;
    logic [31:0] pow10;
    int          sel;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes and special cases of every format
    send_word(irp_pkg::KindUdec, 32'd0);
    send_word(irp_pkg::KindUdec, 32'd1);
    send_word(irp_pkg::KindUdec, 32'd9);
    send_word(irp_pkg::KindUdec, 32'd10);
    send_word(irp_pkg::KindUdec, 32'hFFFF_FFFF);
    send_word(irp_pkg::KindSdec, 32'd0);
    send_word(irp_pkg::KindSdec, 32'd1);
    send_word(irp_pkg::KindSdec, 32'hFFFF_FFFF);
    send_word(irp_pkg::KindSdec, 32'h8000_0000);
    send_word(irp_pkg::KindSdec, 32'h7FFF_FFFF);
    send_word(irp_pkg::KindSdec, -32'sd10);
    send_word(irp_pkg::KindOct,  32'd0);
    send_word(irp_pkg::KindOct,  32'd7);
    send_word(irp_pkg::KindOct,  32'd8);
    send_word(irp_pkg::KindOct,  32'hFFFF_FFFF);
    send_word(irp_pkg::KindOct,  32'h4000_0000);
    send_word(irp_pkg::KindHex,  32'd0);
    send_word(irp_pkg::KindHex,  32'd1);
    send_word(irp_pkg::KindHex,  32'h10);
    send_word(irp_pkg::KindHex,  32'hABCD_EF01);
    send_word(irp_pkg::KindHex,  32'hFFFF_FFFF);
    drain();

    // Random words, rotating through the idle and stall mixes
    for (int n = 0; n < RandomWords; n++) begin
      if (n % PhaseWords == 0) begin
        case ((n / PhaseWords) % 4)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 85; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 85; end
          default: begin idle_pct = 6; stall_pct = 6; end
        endcase
      end
      sel = $urandom_range(7);
      case (sel)
        0, 1: word = $urandom();
        2: word = $urandom_range(999);
        3: word = (32'd1 << $urandom_range(31)) - $urandom_range(1);
        4: word = -$urandom_range(1000);
        5: word = 32'hFFFF_FFFF >> $urandom_range(31);
        6: begin
          pow10 = 32'd1;
          repeat ($urandom_range(9)) pow10 = pow10 * 10;
          word = pow10 - $urandom_range(1);
        end
        default: begin
          case ($urandom_range(2))
            0: word = 32'h8000_0000;
            1: word = 32'h7FFF_FFFF;
            default: word = 32'd0;
          endcase
        end
      endcase
      send_word(irp_pkg::kind_e'($urandom_range(3)), word);
      // pause mid-run so the pipeline empties once with traffic around it
      if (n == RandomWords / 2) drain();
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
